/* rtl/core/stt_pkg.sv */
`timescale 1ns / 1ps

package stt_pkg;

  // History geometry
  localparam int unsigned HistDepth = 10;
  localparam int unsigned HistIdxW  = $clog2(HistDepth);
  localparam int unsigned SpeedupW  = 16;
  localparam int unsigned SumW      = SpeedupW + $clog2(HistDepth + 1);

  // Limit widths, reset values and clamps
  localparam int unsigned SimdLimW = 13;
  localparam int unsigned GpuLimW  = 23;

  localparam logic [SimdLimW-1:0] SimdReset = SimdLimW'(256);
  localparam logic [SimdLimW-1:0] SimdMin   = SimdLimW'(64);
  localparam logic [SimdLimW-1:0] SimdMax   = SimdLimW'(4096);
  localparam logic [GpuLimW-1:0]  GpuReset  = GpuLimW'(262144);
  localparam logic [GpuLimW-1:0]  GpuMin    = GpuLimW'(65536);
  localparam logic [GpuLimW-1:0]  GpuMax    = GpuLimW'(4194304);

  // Average bounds in Q8.8, scaled by depth (SIMD side is compared at sum*10)
  localparam logic [31:0] SimdUpBound  = 32'(HistDepth * 3840);
  localparam logic [31:0] SimdLowBound = 32'(HistDepth * 2816);
  localparam logic [31:0] GpuUpBound   = 32'(HistDepth * 2560);
  localparam logic [31:0] GpuLowBound  = 32'(HistDepth * 768);

  // Shared multiplier: scale factor, then reciprocal of 5 or 10
  localparam int unsigned MulW = 32;
  localparam logic [MulW-1:0] RecipMul  = 32'hCCCC_CCCD;
  localparam int unsigned     SimdShift = 34;  // x / 5
  localparam int unsigned     GpuShift  = 35;  // x / 10

  localparam logic [3:0] SimdDecFactor = 4'd4;
  localparam logic [3:0] SimdIncFactor = 4'd6;
  localparam logic [3:0] GpuDecFactor  = 4'd7;
  localparam logic [3:0] GpuIncFactor  = 4'd13;

  typedef struct packed {
    logic                wr_en;
    logic                wr_simd;
    logic [HistIdxW-1:0] wr_idx;
    logic [SpeedupW-1:0] wr_data;
    logic                acc_clr;
    logic                acc_en;
    logic [HistIdxW-1:0] rd_idx;
  } hist_ctrl_t;

endpackage

/* rtl/core/stt_history.sv */
`timescale 1ns / 1ps

module stt_history (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  stt_pkg::hist_ctrl_t          ctrl_i,
  output logic [stt_pkg::SumW-1:0]     simd_sum_o,
  output logic [stt_pkg::SumW-1:0]     gpu_sum_o
);
  import stt_pkg::*;

  logic [SpeedupW-1:0] simd_hist_q [HistDepth];
  logic [SpeedupW-1:0] gpu_hist_q  [HistDepth];
  logic [SumW-1:0]     simd_sum_q, simd_sum_d;
  logic [SumW-1:0]     gpu_sum_q, gpu_sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        simd_hist_q[i] <= '0;
        gpu_hist_q[i]  <= '0;
      end
    end else if (ctrl_i.wr_en) begin
      // only the reporting path's entry moves
      if (ctrl_i.wr_simd) begin
        simd_hist_q[ctrl_i.wr_idx] <= ctrl_i.wr_data;
      end else begin
        gpu_hist_q[ctrl_i.wr_idx] <= ctrl_i.wr_data;
      end
    end
  end

  // while acc_en is set, one entry of each history per cycle into the running sums
  always_comb begin
    simd_sum_d = simd_sum_q;
    gpu_sum_d  = gpu_sum_q;
    if (ctrl_i.acc_clr) begin
      simd_sum_d = '0;
      gpu_sum_d  = '0;
    end else if (ctrl_i.acc_en) begin
      simd_sum_d = simd_sum_q + SumW'(simd_hist_q[ctrl_i.rd_idx]);
      gpu_sum_d  = gpu_sum_q + SumW'(gpu_hist_q[ctrl_i.rd_idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      simd_sum_q <= '0;
      gpu_sum_q  <= '0;
    end else begin
      simd_sum_q <= simd_sum_d;
      gpu_sum_q  <= gpu_sum_d;
    end
  end

  assign simd_sum_o = simd_sum_q;
  assign gpu_sum_o  = gpu_sum_q;

endmodule

/* rtl/core/speedup_threshold_tuner_top.sv */
`timescale 1ns / 1ps

// Speedup threshold tuner.
// Input channel (in_valid_i / in_ready_o) carries one speedup report per request:
// a path flag and a Q8.8 speedup. Output channel (out_valid_o / out_ready_i)
// returns one result per request: both current limits and an adjusted flag.
// The enable register lives at byte address 0 of the APB port; while it is 0
// requests are passed straight through with the limits unchanged.
// An ordinary request's result is registered and shows in the cycle after
// acceptance. Every HistDepth-th enabled request starts a tuning pass: it
// sums both histories (one entry each per cycle), takes a decision state and
// three steps per limit through the shared multiplier (scale, reciprocal,
// clamp), then a response state, and the result goes to the output register.
// One request is in flight at a time; in_ready_o is high only when idle and
// the output register is empty or being emptied.
// Reset clears both histories, the slot counter and enable, and loads the
// limits with 256 and 262144. A stalled receiver just holds the result in the
// output register; the tuning pass waits in its response cycle until it drains.
module speedup_threshold_tuner_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // report requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            is_simd_i,
  input  logic [stt_pkg::SpeedupW-1:0]    speedup_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stt_pkg::SimdLimW-1:0]    simd_threshold_o,
  output logic [stt_pkg::GpuLimW-1:0]     gpu_threshold_o,
  output logic                            adjusted_o
);
  import stt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StDec   = 3'd2;
  localparam logic [2:0] StMulA  = 3'd3;
  localparam logic [2:0] StMulB  = 3'd4;
  localparam logic [2:0] StApply = 3'd5;
  localparam logic [2:0] StResp  = 3'd6;

  localparam logic RegEnable = 1'b0;  // paddr[2] selects the register index

  logic [2:0] state_q, state_d;

  logic                enable_q, enable_d;
  logic [HistIdxW-1:0] slot_q, slot_d;
  logic [HistIdxW-1:0] cnt_q, cnt_d;
  logic [SimdLimW-1:0] simd_lim_q, simd_lim_d;
  logic [GpuLimW-1:0]  gpu_lim_q, gpu_lim_d;
  logic                s_dec_q, s_dec_d, s_inc_q, s_inc_d;
  logic                g_dec_q, g_dec_d, g_inc_q, g_inc_d;
  logic                unit_gpu_q, unit_gpu_d;
  logic [2*MulW-1:0]   prod_q, prod_d;

  logic                out_valid_q, out_valid_d;
  logic [SimdLimW-1:0] out_simd_q, out_simd_d;
  logic [GpuLimW-1:0]  out_gpu_q, out_gpu_d;
  logic                out_adj_q, out_adj_d;

  hist_ctrl_t      hctrl;
  logic [SumW-1:0] simd_sum, gpu_sum;

  logic            in_fire, out_free, cfg_wr;
  logic [MulW-1:0] mul_a, mul_b;
  logic [31:0]     simd_sum_x10, gpu_sum_x;
  logic [GpuLimW-1:0]  quot;
  logic [SimdLimW-1:0] simd_new;
  logic [GpuLimW-1:0]  gpu_new;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    enable_d = enable_q;
    if (cfg_wr && paddr[2] == RegEnable) begin
      enable_d = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegEnable) ? {31'b0, enable_q} : '0;

  // ---------------------------------------------------------------- history
  stt_history u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hctrl),
    .simd_sum_o (simd_sum),
    .gpu_sum_o  (gpu_sum)
  );

  // ---------------------------------------------------------------- shared multiplier
  // first pass: limit times small factor; second pass: times reciprocal
  always_comb begin
    if (state_q == StMulB) begin
      mul_a = prod_q[MulW-1:0];
      mul_b = RecipMul;
    end else if (unit_gpu_q) begin
      mul_a = MulW'(gpu_lim_q);
      mul_b = MulW'(g_dec_q ? GpuDecFactor : GpuIncFactor);
    end else begin
      mul_a = MulW'(simd_lim_q);
      mul_b = MulW'(s_dec_q ? SimdDecFactor : SimdIncFactor);
    end
  end

  // sums are at most 20 bits, so the x10 fits easily in 32
  assign simd_sum_x10 = (32'(simd_sum) << 3) + (32'(simd_sum) << 1);
  assign gpu_sum_x    = 32'(gpu_sum);

  // quotient and clamps
  always_comb begin
    if (unit_gpu_q) begin
      quot = prod_q[GpuShift +: GpuLimW];
    end else begin
      quot = GpuLimW'(prod_q[SimdShift +: SimdLimW]);
    end

    simd_new = simd_lim_q;
    if (s_dec_q) begin
      simd_new = (quot[SimdLimW-1:0] < SimdMin) ? SimdMin : quot[SimdLimW-1:0];
    end else if (s_inc_q) begin
      simd_new = (quot[SimdLimW-1:0] > SimdMax) ? SimdMax : quot[SimdLimW-1:0];
    end

    gpu_new = gpu_lim_q;
    if (g_dec_q) begin
      gpu_new = (quot < GpuMin) ? GpuMin : quot;
    end else if (g_inc_q) begin
      gpu_new = (quot > GpuMax) ? GpuMax : quot;
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    simd_lim_d  = simd_lim_q;
    gpu_lim_d   = gpu_lim_q;
    s_dec_d     = s_dec_q;
    s_inc_d     = s_inc_q;
    g_dec_d     = g_dec_q;
    g_inc_d     = g_inc_q;
    unit_gpu_d  = unit_gpu_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_simd_d  = out_simd_q;
    out_gpu_d   = out_gpu_q;
    out_adj_d   = out_adj_q;

    hctrl         = '0;
    hctrl.wr_simd = is_simd_i;
    hctrl.wr_idx  = slot_q;
    hctrl.wr_data = speedup_i;
    hctrl.rd_idx  = cnt_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (enable_q) begin
            hctrl.wr_en = 1'b1;
            if (slot_q == HistIdxW'(HistDepth - 1)) begin
              // slot wraps: run a tuning pass before answering
              slot_d        = '0;
              cnt_d         = '0;
              hctrl.acc_clr = 1'b1;
              state_d       = StSum;
            end else begin
              slot_d      = slot_q + 1'b1;
              out_valid_d = 1'b1;
              out_simd_d  = simd_lim_q;
              out_gpu_d   = gpu_lim_q;
              out_adj_d   = 1'b0;
            end
          end else begin
            out_valid_d = 1'b1;
            out_simd_d  = simd_lim_q;
            out_gpu_d   = gpu_lim_q;
            out_adj_d   = 1'b0;
          end
        end
      end
      StSum: begin
        hctrl.acc_en = 1'b1;
        if (cnt_q == HistIdxW'(HistDepth - 1)) begin
          state_d = StDec;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDec: begin
        s_dec_d    = simd_sum_x10 > SimdUpBound;
        s_inc_d    = simd_sum_x10 < SimdLowBound;
        g_dec_d    = gpu_sum_x > GpuUpBound;
        g_inc_d    = gpu_sum_x < GpuLowBound;
        unit_gpu_d = 1'b0;
        state_d    = StMulA;
      end
      StMulA: begin
        prod_d  = mul_a * mul_b;
        state_d = StMulB;
      end
      StMulB: begin
        prod_d  = mul_a * mul_b;
        state_d = StApply;
      end
      StApply: begin
        if (unit_gpu_q) begin
          gpu_lim_d = gpu_new;
          state_d   = StResp;
        end else begin
          simd_lim_d = simd_new;
          unit_gpu_d = 1'b1;
          state_d    = StMulA;
        end
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_simd_d  = simd_lim_q;
          out_gpu_d   = gpu_lim_q;
          out_adj_d   = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      enable_q    <= 1'b0;
      slot_q      <= '0;
      cnt_q       <= '0;
      simd_lim_q  <= SimdReset;
      gpu_lim_q   <= GpuReset;
      s_dec_q     <= 1'b0;
      s_inc_q     <= 1'b0;
      g_dec_q     <= 1'b0;
      g_inc_q     <= 1'b0;
      unit_gpu_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      enable_q    <= enable_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      simd_lim_q  <= simd_lim_d;
      gpu_lim_q   <= gpu_lim_d;
      s_dec_q     <= s_dec_d;
      s_inc_q     <= s_inc_d;
      g_dec_q     <= g_dec_d;
      g_inc_q     <= g_inc_d;
      unit_gpu_q  <= unit_gpu_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    out_simd_q <= out_simd_d;
    out_gpu_q  <= out_gpu_d;
    out_adj_q  <= out_adj_d;
  end

  assign out_valid_o      = out_valid_q;
  assign simd_threshold_o = out_simd_q;
  assign gpu_threshold_o  = out_gpu_q;
  assign adjusted_o       = out_adj_q;

endmodule
